/* hdl/lnrx_pkg.sv */
package lnrx_pkg;

  typedef enum logic [3:0] {
    K_POWEROFF  = 4'd0,
    K_POWERON   = 4'd1,
    K_SWITCHREQ = 4'd2,
    K_INPUTREP  = 4'd3,
    K_SPEED     = 4'd4,
    K_FLAGS     = 4'd5,
    K_SLOTREQ   = 4'd6,
    K_ADRREQ    = 4'd7,
    K_ACK       = 4'd8,
    K_SLOTDATA  = 4'd9,
    K_OTHERSLOT = 4'd10,
    K_IGNORED   = 4'd11
  } kind_t;

  localparam logic [7:0] OP_POWEROFF  = 8'h82;
  localparam logic [7:0] OP_POWERON   = 8'h83;
  localparam logic [7:0] OP_SWITCHREQ = 8'hb0;
  localparam logic [7:0] OP_INPUTREP  = 8'hb2;
  localparam logic [7:0] OP_SPEED     = 8'ha0;
  localparam logic [7:0] OP_FLAGS     = 8'ha1;
  localparam logic [7:0] OP_SLOTREQ   = 8'hbb;
  localparam logic [7:0] OP_ADRREQ    = 8'hbf;
  localparam logic [7:0] OP_ACK       = 8'hb4;
  localparam logic [7:0] OP_SLOTREAD  = 8'he7;

  localparam logic [7:0] SLOT_DATA_COUNT = 8'h0e;

  // opcode class in the top three bits
  localparam logic [2:0] CLS_2BYTE = 3'b100;
  localparam logic [2:0] CLS_4BYTE = 3'b101;
  localparam logic [2:0] CLS_6BYTE = 3'b110;

  // one slot map write request
  typedef struct packed {
    logic        en;
    logic [6:0]  slot;
    logic [13:0] addr;
  } map_wr_t;

endpackage

/* hdl/loconet_rx_deframer_decoder.sv */
// Receive-side packet deframer and message decoder for the model railway bus.
// One bus byte is taken per request on the in_ channel and at most one decoded
// message leaves per request on the out_ channel. Bytes below 0x80 are
// dropped while hunting for an opcode; the packet length follows the opcode
// class (2, 4 or 6 bytes) or, for the variable class, the count byte, which
// is clamped to the range 2 to MAX_PACKET. The checksum byte ends the packet
// but is not checked. The block sustains one byte per clock: in_ready only
// drops while a finished message waits in the output register and out_ready
// is low. A message appears on out_ in the cycle after its last byte is taken.
// Slot data messages write a slot-to-decoder-address map held in a single
// synchronous RAM of SLOT_COUNT entries with per-entry valid bits cleared at
// reset (no clearing pass); loco speed messages read it when their slot byte
// arrives, so the RAM read latency is hidden behind the speed byte.
module loconet_rx_deframer_decoder #(
  parameter int SLOT_COUNT = 128,
  parameter int MAX_PACKET = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_kind,
  output logic [7:0]  out_opcode_seen,
  output logic [13:0] out_address,
  output logic [6:0]  out_slot,
  output logic [6:0]  out_value,
  output logic        out_port,
  output logic [6:0]  out_status
);
  import lnrx_pkg::*;

  localparam int IW = $clog2(MAX_PACKET + 1);

  // framing state
  logic          in_pkt_r, in_pkt_nxt;
  logic [7:0]    op_r, op_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] len_r, len_nxt;

  // header bytes that the decoder needs (byte 1 kept whole for the count check)
  logic [7:0]    h1_r, h1_nxt;
  logic [6:0]    h2_r, h2_nxt;
  logic [6:0]    h3_r, h3_nxt;
  logic [6:0]    h4_r, h4_nxt;
  logic [6:0]    h5_r, h5_nxt;
  logic [6:0]    h9_r, h9_nxt;

  // output register
  logic          out_valid_r;
  kind_t         kind_r, kind_nxt;
  logic [7:0]    opc_r;
  logic [13:0]   addr_r, addr_nxt;
  logic [6:0]    slot_r, slot_nxt;
  logic [6:0]    val_r, val_nxt;
  logic          port_r, port_nxt;
  logic [6:0]    stat_r, stat_nxt;

  logic          in_fire;
  logic          pkt_byte;
  logic          pkt_done;
  logic [IW-1:0] idx_inc;
  logic [IW-1:0] len_eff;
  logic [IW-1:0] cnt_len;
  logic [IW-1:0] cls_len;
  logic [10:0]   lo_addr;
  logic [13:0]   map_addr;
  logic          map_rd;
  map_wr_t       map_wr;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign pkt_byte = in_fire && in_pkt_r;

  // length from the opcode class, zero for the counted class
  always_comb begin
    case (in_rx_byte[7:5])
      CLS_2BYTE: cls_len = IW'(2);
      CLS_4BYTE: cls_len = IW'(4);
      CLS_6BYTE: cls_len = IW'(6);
      default:   cls_len = '0;
    endcase
  end

  // count byte clamped to 2 .. MAX_PACKET
  always_comb begin
    if (in_rx_byte < 8'd2) begin
      cnt_len = IW'(2);
    end else if (in_rx_byte > 8'(MAX_PACKET)) begin
      cnt_len = IW'(MAX_PACKET);
    end else begin
      cnt_len = in_rx_byte[IW-1:0];
    end
  end

  assign len_eff  = (idx_r == IW'(1) && len_r == '0) ? cnt_len : len_r;
  assign idx_inc  = idx_r + IW'(1);
  assign pkt_done = pkt_byte && (idx_inc >= len_eff);

  // framing next state
  always_comb begin
    in_pkt_nxt = in_pkt_r;
    op_nxt     = op_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    if (in_fire) begin
      if (!in_pkt_r) begin
        if (in_rx_byte[7]) begin
          in_pkt_nxt = 1'b1;
          op_nxt     = in_rx_byte;
          idx_nxt    = IW'(1);
          len_nxt    = cls_len;
        end
      end else if (pkt_done) begin
        in_pkt_nxt = 1'b0;
        idx_nxt    = '0;
        len_nxt    = '0;
      end else begin
        idx_nxt = idx_inc;
        len_nxt = len_eff;
      end
    end
  end

  // header capture, the current byte is visible to the decoder at once
  always_comb begin
    h1_nxt = h1_r;
    h2_nxt = h2_r;
    h3_nxt = h3_r;
    h4_nxt = h4_r;
    h5_nxt = h5_r;
    h9_nxt = h9_r;
    if (pkt_byte) begin
      if (idx_r == IW'(1)) h1_nxt = in_rx_byte;
      if (idx_r == IW'(2)) h2_nxt = in_rx_byte[6:0];
      if (idx_r == IW'(3)) h3_nxt = in_rx_byte[6:0];
      if (idx_r == IW'(4)) h4_nxt = in_rx_byte[6:0];
      if (idx_r == IW'(5)) h5_nxt = in_rx_byte[6:0];
      if (idx_r == IW'(9)) h9_nxt = in_rx_byte[6:0];
    end
  end

  // slot map lookup starts on byte 1 of every packet (the slot byte of a speed message)
  assign map_rd = pkt_byte && (idx_r == IW'(1));

  assign lo_addr = {h2_nxt[3:0], h1_nxt[6:0]};

  // message decode
  always_comb begin
    kind_nxt = K_IGNORED;
    addr_nxt = '0;
    slot_nxt = '0;
    val_nxt  = '0;
    port_nxt = 1'b0;
    stat_nxt = '0;
    map_wr   = '0;
    case (op_r)
      OP_POWEROFF: kind_nxt = K_POWEROFF;
      OP_POWERON:  kind_nxt = K_POWERON;
      OP_SWITCHREQ: begin
        kind_nxt = K_SWITCHREQ;
        addr_nxt = 14'(lo_addr) + 14'd1;
        val_nxt  = {6'd0, h2_nxt[4]};
        port_nxt = h2_nxt[5];
      end
      OP_INPUTREP: begin
        kind_nxt = K_INPUTREP;
        addr_nxt = {2'b00, lo_addr, 1'b0} + 14'(h2_nxt[5]) + 14'd1;
        val_nxt  = {6'd0, h2_nxt[4]};
        port_nxt = h2_nxt[5];
      end
      OP_SPEED: begin
        kind_nxt = K_SPEED;
        slot_nxt = h1_nxt[6:0];
        val_nxt  = h2_nxt;
        addr_nxt = map_addr;
      end
      OP_FLAGS: begin
        kind_nxt = K_FLAGS;
        slot_nxt = h1_nxt[6:0];
        val_nxt  = h2_nxt;
      end
      OP_SLOTREQ: begin
        kind_nxt = K_SLOTREQ;
        slot_nxt = h1_nxt[6:0];
      end
      OP_ADRREQ: begin
        kind_nxt = K_ADRREQ;
        addr_nxt = {h1_nxt[6:0], h2_nxt};
      end
      OP_ACK: begin
        kind_nxt = K_ACK;
        stat_nxt = h1_nxt[6:0];
        val_nxt  = h2_nxt;
      end
      OP_SLOTREAD: begin
        if (h1_nxt == SLOT_DATA_COUNT) begin
          kind_nxt    = K_SLOTDATA;
          slot_nxt    = h2_nxt;
          stat_nxt    = h3_nxt;
          addr_nxt    = {h9_nxt, h4_nxt};
          val_nxt     = h5_nxt;
          map_wr.en   = pkt_done;
          map_wr.slot = h2_nxt;
          map_wr.addr = {h9_nxt, h4_nxt};
        end else begin
          kind_nxt = K_OTHERSLOT;
        end
      end
      default: kind_nxt = K_IGNORED;
    endcase
  end

  lnrx_slot_map #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (map_wr),
    .rd_en   (map_rd),
    .rd_slot (in_rx_byte[6:0]),
    .rd_addr (map_addr)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_pkt_r    <= 1'b0;
      op_r        <= '0;
      idx_r       <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_pkt_r <= in_pkt_nxt;
      op_r     <= op_nxt;
      idx_r    <= idx_nxt;
      len_r    <= len_nxt;
      if (pkt_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    h1_r <= h1_nxt;
    h2_r <= h2_nxt;
    h3_r <= h3_nxt;
    h4_r <= h4_nxt;
    h5_r <= h5_nxt;
    h9_r <= h9_nxt;
    if (pkt_done) begin
      kind_r <= kind_nxt;
      opc_r  <= op_r;
      addr_r <= addr_nxt;
      slot_r <= slot_nxt;
      val_r  <= val_nxt;
      port_r <= port_nxt;
      stat_r <= stat_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_opcode_seen = opc_r;
  assign out_address     = addr_r;
  assign out_slot        = slot_r;
  assign out_value       = val_r;
  assign out_port        = port_r;
  assign out_status      = stat_r;

  // an idle output side never stalls the byte stream
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output register");

  // inside a packet the opcode has always been taken
  a_index_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    in_pkt_r |-> idx_r != '0)
    else $error("packet open with zero byte index");

  // a known length is never already reached while the packet is open
  a_index_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pkt_r && len_r != '0) |-> idx_r < len_r)
    else $error("byte index past packet length");

  // a finished packet always yields a message in the next cycle
  a_done_gives_msg: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_done |=> out_valid_r && !in_pkt_r)
    else $error("completed packet did not produce a message");

endmodule

/* hdl/lnrx_slot_map.sv */
module lnrx_slot_map #(
  parameter int SLOT_COUNT = 128
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lnrx_pkg::map_wr_t wr,
  input  logic            rd_en,
  input  logic [6:0]      rd_slot,
  output logic [13:0]     rd_addr
);
  import lnrx_pkg::*;

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [13:0]           mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld_r;
  logic [13:0]           rd_r;
  logic                  rdv_r;
  logic                  wr_hit;
  logic                  rd_hit;

  assign wr_hit = wr.en && ({1'b0, wr.slot} < 8'(SLOT_COUNT));
  assign rd_hit = {1'b0, rd_slot} < 8'(SLOT_COUNT);

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr.slot[AW-1:0]] <= wr.addr;
    end
    if (rd_en) begin
      rd_r <= mem[rd_slot[AW-1:0]];
    end
  end

  // entry never written, or a slot beyond SLOT_COUNT, reads as address zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rdv_r <= 1'b0;
    end else begin
      if (wr_hit) begin
        vld_r[wr.slot[AW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rdv_r <= rd_hit && vld_r[rd_slot[AW-1:0]];
      end
    end
  end

  assign rd_addr = rdv_r ? rd_r : 14'd0;

endmodule

/* test/loconet_rx_deframer_decoder_test.sv */
`timescale 1ns / 1ps

module loconet_rx_deframer_decoder_test;
  import lnrx_pkg::*;

  localparam int PKT_MAX     = 128;     // longest packet the block accepts
  localparam int SLOTS       = 128;     // slot map entries
  localparam int HDR_KEPT    = 10;      // leading packet bytes kept for decoding
  localparam int STIM_BYTES  = 1500;    // packet bytes in the random traffic
  localparam int CYCLE_LIMIT = 200000;  // far beyond the slowest correct run
  localparam int PRINT_MAX   = 50;      // mismatch lines printed before going quiet

  // opcodes decoded as ignored, and the variable-length class
  localparam logic [7:0] OP_SWITCHREP = 8'hb1;
  localparam logic [7:0] OP_SIXBYTE   = 8'hc5;
  localparam logic [7:0] OP_VARIABLE  = 8'he5;
  localparam logic [2:0] CLS_VARLEN   = 3'b111;

  localparam logic [7:0] KNOWN_OPS [12] = '{
    OP_POWEROFF, OP_POWERON, OP_SWITCHREQ, OP_INPUTREP, OP_SPEED, OP_FLAGS,
    OP_SLOTREQ, OP_ADRREQ, OP_ACK, OP_SLOTREAD, OP_SLOTREAD, OP_SWITCHREP
  };

  typedef struct {
    kind_t       kind;
    logic [7:0]  opcode;
    logic [13:0] address;
    logic [6:0]  slot;
    logic [6:0]  value;
    logic        port;
    logic [6:0]  status;
  } decoded_msg_t;

  // every input of the block is known from time zero
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_ready  = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [3:0]  out_kind;
  logic [7:0]  out_opcode_seen;
  logic [13:0] out_address;
  logic [6:0]  out_slot;
  logic [6:0]  out_value;
  logic        out_port;
  logic [6:0]  out_status;

  // shadow of the deframer state and the slot map
  logic        in_frame  = 1'b0;
  logic [7:0]  frame_op  = 8'h00;
  int          frame_idx = 0;
  int          frame_len = 0;
  logic [7:0]  frame_hdr [HDR_KEPT];
  logic [13:0] slot_addr [SLOTS];

  decoded_msg_t expected_msgs [$];
  int           fail_count  = 0;
  int           msg_count   = 0;
  int           cycle_count = 0;
  bit           idle_en     = 1'b1;

  loconet_rx_deframer_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_opcode_seen (out_opcode_seen),
    .out_address     (out_address),
    .out_slot        (out_slot),
    .out_value       (out_value),
    .out_port        (out_port),
    .out_status      (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_MAX) $display("mismatch at %0t ns: %s", $realtime, what);
    fail_count++;
  endtask

  // follows one accepted byte through the deframer; a finished packet
  // leaves its decoded message in the queue of expected messages
  task automatic decode_rx_byte(input logic [7:0] b);
    decoded_msg_t m;
    logic [6:0]   d [HDR_KEPT];
    logic [10:0]  lo;
    if (!in_frame) begin
      // hunting: anything without the top bit is line noise
      if (b[7]) begin
        in_frame     = 1'b1;
        frame_op     = b;
        frame_hdr[0] = b;
        frame_idx    = 1;
        case (b[7:5])
          CLS_2BYTE: frame_len = 2;
          CLS_4BYTE: frame_len = 4;
          CLS_6BYTE: frame_len = 6;
          default:   frame_len = 0;  // length comes with the count byte
        endcase
      end
      return;
    end
    if (frame_idx < HDR_KEPT) frame_hdr[frame_idx] = b;
    // count byte covers the whole packet, clamped to 2 .. PKT_MAX
    if (frame_idx == 1 && frame_len == 0)
      frame_len = (b < 2) ? 2 : (b > PKT_MAX) ? PKT_MAX : int'(b);
    frame_idx++;
    if (frame_idx < frame_len) return;

    in_frame  = 1'b0;
    frame_idx = 0;
    frame_len = 0;
    // only the low seven bits of a data byte carry meaning
    foreach (d[i]) d[i] = frame_hdr[i][6:0];
    m.kind    = K_IGNORED;
    m.opcode  = frame_op;
    m.address = '0;
    m.slot    = '0;
    m.value   = '0;
    m.port    = 1'b0;
    m.status  = '0;
    case (frame_op)
      OP_POWEROFF: m.kind = K_POWEROFF;
      OP_POWERON:  m.kind = K_POWERON;
      OP_SWITCHREQ: begin
        m.kind    = K_SWITCHREQ;
        m.address = 14'({d[2][3:0], d[1]}) + 14'd1;
        m.value   = 7'(d[2][4]);
        m.port    = d[2][5];
      end
      OP_INPUTREP: begin
        // sensor address counts both inputs of a port pair
        lo        = {d[2][3:0], d[1]};
        m.kind    = K_INPUTREP;
        m.port    = d[2][5];
        m.address = 14'd1 + 14'(lo) * 14'd2 + 14'(d[2][5]);
        m.value   = 7'(d[2][4]);
      end
      OP_SPEED: begin
        m.kind    = K_SPEED;
        m.slot    = d[1];
        m.value   = d[2];
        m.address = slot_addr[d[1]];
      end
      OP_FLAGS: begin
        m.kind  = K_FLAGS;
        m.slot  = d[1];
        m.value = d[2];
      end
      OP_SLOTREQ: begin
        m.kind = K_SLOTREQ;
        m.slot = d[1];
      end
      OP_ADRREQ: begin
        m.kind    = K_ADRREQ;
        m.address = {d[1], d[2]};
      end
      OP_ACK: begin
        m.kind   = K_ACK;
        m.status = d[1];
        m.value  = d[2];
      end
      OP_SLOTREAD: begin
        // full eight-bit compare: a count with the top bit is another format
        if (frame_hdr[1] == SLOT_DATA_COUNT) begin
          m.kind            = K_SLOTDATA;
          m.slot            = d[2];
          m.status          = d[3];
          m.address         = {d[9], d[4]};
          m.value           = d[5];
          slot_addr[d[2]]   = m.address;
        end else begin
          m.kind = K_OTHERSLOT;
        end
      end
      default: ;
    endcase
    expected_msgs.push_back(m);
  endtask

  // one request on the in_ channel, with random idle cycles ahead of it;
  // valid is only lowered when an idle cycle follows, never between requests
  task automatic send_byte(input logic [7:0] b);
    while (idle_en && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_rx_byte(b);
  endtask

  // sends the packet body followed by its checksum (xor of all bytes is 0xff)
  task automatic send_frame(input logic [7:0] body [$]);
    logic [7:0] sum;
    sum = 8'hff;
    foreach (body[i]) begin
      send_byte(body[i]);
      sum ^= body[i];
    end
    send_byte(sum);
  endtask

  // in_ idles until every message still owed has been taken off out_
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_msgs.size() != 0);
  endtask

  function automatic logic [7:0] rand_data();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 127));
  endfunction

  // slots are bunched low half the time so speed messages find mapped entries
  function automatic logic [7:0] rand_slot();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 127));
  endfunction

  // one packet of a random kind with random content; now and then cut short
  // so that the next opcode is swallowed as a data byte
  task automatic send_random_packet(output int n_sent);
    logic [7:0] pkt [$];
    logic [7:0] op;
    logic [7:0] cnt;
    int         len;
    int         cut;
    if ($urandom_range(0, 4) != 0) op = KNOWN_OPS[$urandom_range(0, 11)];
    else op = 8'($urandom_range(128, 255));
    pkt.push_back(op);
    if (op[7:5] == CLS_VARLEN) begin
      if (op == OP_SLOTREAD && $urandom_range(0, 3) != 0) cnt = SLOT_DATA_COUNT;
      else if ($urandom_range(0, 19) == 0) cnt = 8'($urandom_range(0, 255));
      else cnt = 8'($urandom_range(0, 20));
      pkt.push_back(cnt);
      len = (cnt < 2) ? 2 : (cnt > PKT_MAX) ? PKT_MAX : int'(cnt);
    end else begin
      len = (op[7:5] == CLS_2BYTE) ? 2 : (op[7:5] == CLS_4BYTE) ? 4 : 6;
    end
    while (pkt.size() < len) pkt.push_back(rand_data());
    if (op == OP_SPEED || op == OP_FLAGS || op == OP_SLOTREQ) pkt[1] = rand_slot();
    if (op == OP_SLOTREAD && len > 2) pkt[2] = rand_slot();
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, len - 1) : len;
    for (int i = 0; i < cut; i++) send_byte(pkt[i]);
    // idle-line noise between packets
    if ($urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 127)));
    n_sent = cut;
  endtask

  // bytes below 0x80 are dropped while hunting; two-byte power messages
  task automatic test_hunting_noise();
    send_byte(8'h00);
    send_byte(8'h7f);
    send_byte(8'h41);
    send_frame('{OP_POWEROFF});
    send_frame('{OP_POWERON});
  endtask

  // fixed-length messages at the extremes of their fields, ignored opcodes and a short variable-length packet
  task automatic test_fixed_messages();
    send_frame('{OP_SWITCHREQ, 8'h7f, 8'h3f});
    send_frame('{OP_SWITCHREQ, 8'h00, 8'h00});
    send_frame('{OP_INPUTREP, 8'h7f, 8'h2f});
    send_frame('{OP_FLAGS, 8'h7f, 8'h7f});
    send_frame('{OP_SLOTREQ, 8'h7f, 8'h00});
    send_frame('{OP_ADRREQ, 8'h7f, 8'h7f});
    send_frame('{OP_ACK, 8'h3f, 8'h7f});
    send_frame('{OP_SWITCHREP, 8'h12, 8'h34});
    send_frame('{OP_SIXBYTE, 8'h01, 8'h02, 8'h03, 8'h04});
    send_frame('{OP_VARIABLE, 8'h04, 8'h55});
  endtask

  // slot data fills the map, speed reads it back; unknown slots read zero
  task automatic test_slot_map();
    send_frame('{OP_SPEED, 8'h05, 8'h20});
    send_frame('{OP_SLOTREAD, SLOT_DATA_COUNT, 8'h05, 8'h33, 8'h2a, 8'h40,
                 8'h00, 8'h00, 8'h00, 8'h15, 8'h00, 8'h00, 8'h00});
    send_frame('{OP_SPEED, 8'h05, 8'h00});
    send_frame('{OP_SLOTREAD, SLOT_DATA_COUNT, 8'h7f, 8'h7f, 8'h7f, 8'h7f,
                 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f});
    send_frame('{OP_SPEED, 8'h7f, 8'h7f});
  endtask

  // count below two ends the packet on the count byte; huge counts clamp
  task automatic test_count_limits();
    logic [7:0] body [$];
    send_byte(OP_SLOTREAD);
    send_byte(8'h00);
    send_byte(OP_SLOTREAD);
    send_byte(8'h01);
    body.push_back(OP_SLOTREAD);
    body.push_back(8'hff);
    while (body.size() < PKT_MAX - 1) body.push_back(rand_data());
    send_frame(body);
  endtask

  // once inside a packet a byte with the top bit is data, cut to seven bits
  task automatic test_top_bit_data();
    send_frame('{OP_SWITCHREQ, 8'hff, 8'hbf});
    send_frame('{OP_SLOTREAD, SLOT_DATA_COUNT, 8'h85, 8'hff, 8'h80, 8'h81,
                 8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00});
    send_frame('{OP_SPEED, 8'h85, 8'h81});
    send_frame('{OP_SLOTREAD, 8'h8e, 8'h01, 8'h02});
  endtask

  // mostly well-formed random packets, with a stretch of full throughput
  task automatic test_random_traffic();
    int sent;
    int n;
    sent = 0;
    while (sent < STIM_BYTES) begin
      idle_en = !(sent >= 600 && sent < 1000);
      send_random_packet(n);
      sent += n;
    end
    idle_en = 1'b1;
  endtask

  // sender holds off until the block has handed over everything it owes
  task automatic test_drain_pause();
    int n;
    repeat (3) send_random_packet(n);
    wait_drained();
    repeat (3) send_random_packet(n);
    wait_drained();
    send_frame('{OP_SPEED, 8'h05, 8'h11});
  endtask

  // result side: random back-pressure, each message checked against the
  // oldest one owed
  always @(posedge clk) begin
    decoded_msg_t want;
    if (rst_n && out_valid && out_ready) begin
      msg_count++;
      if (expected_msgs.size() == 0) begin
        report_mismatch($sformatf("message %0d with no packet behind it, kind %0d opcode %02h",
                                  msg_count, out_kind, out_opcode_seen));
      end else begin
        want = expected_msgs.pop_front();
        if (out_kind !== want.kind)
          report_mismatch($sformatf("message %0d kind: got %0d, expected %0d",
                                    msg_count, out_kind, want.kind));
        if (out_opcode_seen !== want.opcode)
          report_mismatch($sformatf("message %0d opcode: got %02h, expected %02h",
                                    msg_count, out_opcode_seen, want.opcode));
        if (out_address !== want.address)
          report_mismatch($sformatf("message %0d address: got %0d, expected %0d",
                                    msg_count, out_address, want.address));
        if (out_slot !== want.slot)
          report_mismatch($sformatf("message %0d slot: got %0d, expected %0d",
                                    msg_count, out_slot, want.slot));
        if (out_value !== want.value)
          report_mismatch($sformatf("message %0d value: got %0d, expected %0d",
                                    msg_count, out_value, want.value));
        if (out_port !== want.port)
          report_mismatch($sformatf("message %0d port: got %0d, expected %0d",
                                    msg_count, out_port, want.port));
        if (out_status !== want.status)
          report_mismatch($sformatf("message %0d status: got %0d, expected %0d",
                                    msg_count, out_status, want.status));
      end
    end
    out_ready <= !idle_en || ($urandom_range(0, 99) >= 20);
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("loconet_rx_deframer_decoder test failed");
    $finish;
  end

  initial begin
    foreach (frame_hdr[i]) frame_hdr[i] = 8'h00;
    foreach (slot_addr[i]) slot_addr[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_hunting_noise();
    test_fixed_messages();
    test_slot_map();
    test_count_limits();
    test_top_bit_data();
    test_random_traffic();
    test_drain_pause();

    // let any stray message show up before the verdict
    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_msgs.size() != 0)
      report_mismatch($sformatf("%0d messages never arrived", expected_msgs.size()));
    if (fail_count == 0) $display("loconet_rx_deframer_decoder test passed");
    else $display("loconet_rx_deframer_decoder test failed");
    $finish;
  end

endmodule
